// ----- rtl/dsvm_pkg.sv -----
// Shared types and constants for the dual-stack word machine core.
// Depends on nothing; imported by every module of the block.
package dsvm_pkg;

  localparam int MEM_CELLS_DEF  = 16384;
  localparam int DATA_DEPTH_DEF = 256;
  localparam int RET_DEPTH_DEF  = 256;
  localparam int INQ_DEPTH_DEF  = 64;

  // request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_STEP  = 2'd2,
    REQ_QUEUE = 2'd3
  } req_t;

  // opcodes
  localparam logic [7:0] OP_NOP   = 8'd0;
  localparam logic [7:0] OP_LIT   = 8'd1;
  localparam logic [7:0] OP_DUP   = 8'd2;
  localparam logic [7:0] OP_DROP  = 8'd3;
  localparam logic [7:0] OP_SWAP  = 8'd4;
  localparam logic [7:0] OP_PUSH  = 8'd5;
  localparam logic [7:0] OP_POP   = 8'd6;
  localparam logic [7:0] OP_JUMP  = 8'd7;
  localparam logic [7:0] OP_CALL  = 8'd8;
  localparam logic [7:0] OP_CCALL = 8'd9;
  localparam logic [7:0] OP_RET   = 8'd10;
  localparam logic [7:0] OP_EQ    = 8'd11;
  localparam logic [7:0] OP_NE    = 8'd12;
  localparam logic [7:0] OP_LT    = 8'd13;
  localparam logic [7:0] OP_GT    = 8'd14;
  localparam logic [7:0] OP_FETCH = 8'd15;
  localparam logic [7:0] OP_STORE = 8'd16;
  localparam logic [7:0] OP_ADD   = 8'd17;
  localparam logic [7:0] OP_SUB   = 8'd18;
  localparam logic [7:0] OP_MUL   = 8'd19;
  localparam logic [7:0] OP_DIVM  = 8'd20;
  localparam logic [7:0] OP_AND   = 8'd21;
  localparam logic [7:0] OP_OR    = 8'd22;
  localparam logic [7:0] OP_XOR   = 8'd23;
  localparam logic [7:0] OP_SHIFT = 8'd24;
  localparam logic [7:0] OP_ZRET  = 8'd25;
  localparam logic [7:0] OP_HALT  = 8'd26;
  localparam logic [7:0] OP_IOENUM = 8'd27;
  localparam logic [7:0] OP_IOQRY = 8'd28;
  localparam logic [7:0] OP_IOACT = 8'd29;

  // I/O device numbers
  localparam logic [63:0] DEV_CHAR_OUT = 64'd0;
  localparam logic [63:0] DEV_CHAR_IN  = 64'd1;
  localparam logic [63:0] DEV_COUNT    = 64'd2;

  localparam logic [63:0] CELL_LOW  = 64'h8000_0000_0000_0001;
  localparam logic [63:0] CELL_HIGH = 64'h7FFF_FFFF_FFFF_FFFE;
  localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic do_req;
    logic word_rd;
    logic word_lat;
    logic op_rd;
    logic mem_rd;
    logic arith_go;
    logic exec;
    logic wr2;
    logic emit;
    logic next_slot;
    logic bundle_end;
    logic status;
  } dsvm_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic running;
    logic need_mem;
    logic need_arith;
    logic arith_busy;
    logic emit_pend;
    logic stop_pend;
    logic last_slot;
    logic slot_free;
  } dsvm_sts_t;

endpackage

// ----- rtl/dsvm_muldiv.sv -----
// Shared multi-cycle arithmetic unit: 64-bit product (three 32x32 partial products)
// and unsigned 64-bit restoring division, one quotient bit a cycle. Uses dsvm_pkg.
module dsvm_muldiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic        mul,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        busy,
  output logic [63:0] prod,
  output logic [63:0] quo,
  output logic [63:0] rem
);
  import dsvm_pkg::*;

  logic        mode_mul;
  logic [5:0]  cnt;
  logic [63:0] xa;
  logic [63:0] xb;
  logic [31:0] pa;
  logic [31:0] pb;
  logic [63:0] pp;
  logic [64:0] r_sh;

  always_comb begin
    case (cnt[1:0])
      2'd0:    begin pa = xa[31:0];  pb = xb[31:0];  end
      2'd1:    begin pa = xa[31:0];  pb = xb[63:32]; end
      default: begin pa = xa[63:32]; pb = xb[31:0];  end
    endcase
    pp   = {32'd0, pa} * {32'd0, pb};
    r_sh = {rem, quo[63]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy     <= 1'b1;
      cnt      <= '0;
      mode_mul <= mul;
      xa       <= a;
      xb       <= b;
      prod     <= '0;
      quo      <= a;
      rem      <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (mode_mul) begin
        // accumulate partial products, cross terms shifted up one half
        if (cnt == 6'd0) prod <= pp;
        else             prod <= prod + {pp[31:0], 32'd0};
        if (cnt == 6'd2) busy <= 1'b0;
      end else begin
        if (r_sh >= {1'b0, xb}) begin
          rem <= 64'(r_sh - {1'b0, xb});
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= r_sh[63:0];
          quo <= {quo[62:0], 1'b0};
        end
        if (cnt == 6'd63) busy <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/dsvm_datapath.sv -----
// Datapath of the word machine: main memory, both stacks, input queue, opcode
// execution and the output register. Uses dsvm_pkg and dsvm_muldiv.
module dsvm_datapath #(
  parameter int MEM_CELLS  = dsvm_pkg::MEM_CELLS_DEF,
  parameter int DATA_DEPTH = dsvm_pkg::DATA_DEPTH_DEF,
  parameter int RET_DEPTH  = dsvm_pkg::RET_DEPTH_DEF,
  parameter int INQ_DEPTH  = dsvm_pkg::INQ_DEPTH_DEF,
  parameter int AW         = $clog2(MEM_CELLS + 1),
  parameter int DW         = $clog2(DATA_DEPTH + 1),
  parameter int OW         = ((8 + 1 + AW + DW + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  dsvm_pkg::dsvm_cmd_t cmd,
  output dsvm_pkg::dsvm_sts_t sts,
  input  logic [1:0]          req_type,
  input  logic [AW-1:0]       req_addr,
  input  logic [63:0]         req_value,
  input  logic [7:0]          req_char,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OW-1:0]       m_tdata,
  output logic                m_tuser,
  output logic                m_tlast
);
  import dsvm_pkg::*;

  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int RW  = $clog2(RET_DEPTH + 1);
  localparam int RAW = $clog2(RET_DEPTH);
  localparam int QAW = $clog2(INQ_DEPTH);
  localparam int QCW = $clog2(INQ_DEPTH + 1);

  // storage
  logic [63:0] mem [MEM_CELLS + 1];
  logic [63:0] dstk [DATA_DEPTH];
  logic [63:0] rstk [RET_DEPTH];
  logic [7:0]  inq [INQ_DEPTH];

  // request latch
  req_t        r_type;
  logic [AW-1:0] r_addr;
  logic [63:0] r_value;
  logic [7:0]  r_char;

  // machine state
  logic [AW-1:0]  pc;
  logic           running;
  logic [DW-1:0]  dp;
  logic [RW-1:0]  rp;
  logic [63:0]    cur_ip;
  logic [31:0]    word;
  logic [1:0]     slot;
  logic [QAW-1:0] q_head;
  logic [QAW-1:0] q_tail;
  logic [QCW-1:0] q_count;
  logic [AW-1:0]  clr_cnt;
  logic           stop_q;
  logic           wr2_pend;
  logic [DAW-1:0] wr2_a;
  logic [63:0]    wr2_v;
  logic           emit_pend;
  logic [7:0]     emit_c;

  // registered read data
  logic [63:0] mem_q;
  logic [63:0] ds_q0;
  logic [63:0] ds_q1;
  logic [63:0] rs_q;
  logic [7:0]  qh_q;

  // operand view
  logic [7:0]  op;
  logic [63:0] t;
  logic [63:0] n;
  logic [63:0] r;
  logic        d_z;
  logic        d_one;
  logic        d_ge2;
  logic        d_room;
  logic [DAW-1:0] idx_top;
  logic [DAW-1:0] idx_sec;
  logic [DAW-1:0] idx_push;
  logic [63:0] lit_addr;
  logic        lit_ok;
  logic        fetch_ok;
  logic [63:0] ip_end;

  // arithmetic
  logic        md_busy;
  logic [63:0] md_prod;
  logic [63:0] md_quo;
  logic [63:0] md_rem;
  logic [63:0] ma;
  logic [63:0] mb;
  logic [63:0] neg_t;
  logic [63:0] shv;
  logic [63:0] divq;
  logic [63:0] divr;
  logic [63:0] fv;
  logic [63:0] bv;
  logic        is_bin;
  logic [DW-1:0] base;

  // execution results
  logic           x_stop;
  logic [DW-1:0]  x_dp;
  logic [RW-1:0]  x_rp;
  logic [63:0]    x_ip;
  logic           x_w0_en;
  logic [DAW-1:0] x_w0_a;
  logic [63:0]    x_w0_v;
  logic           x_w1_en;
  logic [DAW-1:0] x_w1_a;
  logic [63:0]    x_w1_v;
  logic           x_rs_we;
  logic [63:0]    x_rs_wv;
  logic           x_mem_we;
  logic           x_emit;
  logic           x_pop;

  // memory ports
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  logic [63:0]    mem_wv;
  logic           mem_re;
  logic [AW-1:0]  mem_ra;
  logic           ds_we;
  logic [DAW-1:0] ds_wa;
  logic [63:0]    ds_wv;
  logic           rs_we;
  logic [RAW-1:0] rs_wa;
  logic [63:0]    rs_wv;
  logic           q_we;

  always_comb begin
    op       = word[{slot, 3'b000} +: 8];
    d_z      = (dp == '0);
    d_one    = (dp == DW'(1));
    d_ge2    = !d_z && !d_one;
    d_room   = (dp < DW'(DATA_DEPTH));
    t        = d_z ? 64'd0 : ds_q0;
    n        = d_ge2 ? ds_q1 : 64'd0;
    r        = (rp == '0) ? 64'd0 : rs_q;
    idx_top  = DAW'(dp - DW'(1));
    idx_sec  = DAW'(dp - DW'(2));
    idx_push = DAW'(dp);
    lit_addr = cur_ip + 64'd1;
    lit_ok   = (lit_addr <= 64'(MEM_CELLS));
    fetch_ok = (t <= 64'(MEM_CELLS));
    ip_end   = cur_ip + 64'd1;
    neg_t    = 64'd0 - t;
    ma       = t[63] ? neg_t : t;
    mb       = n[63] ? (64'd0 - n) : n;
    base     = d_z ? DW'(0) : DW'(dp - DW'(1));
  end

  // shift, divide fix-up, fetch value, two-operand results
  always_comb begin
    if (t[63])           shv = (neg_t >= 64'd64) ? 64'd0 : (n << neg_t[5:0]);
    else if (t >= 64'd64) shv = {64{n[63]}};
    else                 shv = 64'($signed(n) >>> t[5:0]);

    if (t == 64'd0) begin
      divq = 64'd0;
      divr = 64'd0;
    end else begin
      divq = (t[63] ^ n[63]) ? (64'd0 - md_quo) : md_quo;
      divr = n[63] ? (64'd0 - md_rem) : md_rem;
    end

    if (t == ALL_ONES)                 fv = 64'(dp) - 64'd1;
    else if (t == ALL_ONES - 64'd1)    fv = 64'(rp);
    else if (t == ALL_ONES - 64'd2)    fv = 64'(MEM_CELLS);
    else if (t == ALL_ONES - 64'd3)    fv = CELL_LOW;
    else if (t == ALL_ONES - 64'd4)    fv = CELL_HIGH;
    else if (fetch_ok)                 fv = mem_q;
    else                               fv = 64'd0;

    is_bin = 1'b1;
    case (op)
      OP_EQ:    bv = (n == t) ? ALL_ONES : 64'd0;
      OP_NE:    bv = (n != t) ? ALL_ONES : 64'd0;
      OP_LT:    bv = ($signed(n) < $signed(t)) ? ALL_ONES : 64'd0;
      OP_GT:    bv = ($signed(t) < $signed(n)) ? ALL_ONES : 64'd0;
      OP_ADD:   bv = n + t;
      OP_SUB:   bv = n - t;
      OP_MUL:   bv = md_prod;
      OP_AND:   bv = n & t;
      OP_OR:    bv = n | t;
      OP_XOR:   bv = n ^ t;
      OP_SHIFT: bv = shv;
      default: begin
        bv     = 64'd0;
        is_bin = 1'b0;
      end
    endcase
  end

  // one opcode against the stack snapshot
  always_comb begin
    x_stop   = 1'b0;
    x_dp     = dp;
    x_rp     = rp;
    x_ip     = cur_ip;
    x_w0_en  = 1'b0;
    x_w0_a   = idx_top;
    x_w0_v   = 64'd0;
    x_w1_en  = 1'b0;
    x_w1_a   = idx_sec;
    x_w1_v   = 64'd0;
    x_rs_we  = 1'b0;
    x_rs_wv  = 64'd0;
    x_mem_we = 1'b0;
    x_emit   = 1'b0;
    x_pop    = 1'b0;
    if (is_bin) begin
      x_w0_en = d_ge2;
      x_w0_a  = idx_sec;
      x_w0_v  = bv;
      if (d_z) x_stop = 1'b1;
      else     x_dp = dp - DW'(1);
    end else begin
      case (op)
        OP_NOP: ;
        OP_LIT, OP_DUP, OP_IOENUM: begin
          if (op == OP_LIT) x_ip = lit_addr;
          if (d_room) begin
            x_w0_en = 1'b1;
            x_w0_a  = idx_push;
            x_dp    = dp + DW'(1);
          end
          case (op)
            OP_LIT:  x_w0_v = lit_ok ? mem_q : 64'd0;
            OP_DUP:  x_w0_v = t;
            default: x_w0_v = DEV_COUNT;
          endcase
        end
        OP_DROP, OP_JUMP: begin
          if (op == OP_JUMP) x_ip = t - 64'd1;
          if (d_z) x_stop = 1'b1;
          else     x_dp = dp - DW'(1);
        end
        OP_SWAP: begin
          x_w0_en = !d_z;
          x_w0_v  = n;
          x_w1_en = d_ge2;
          x_w1_v  = t;
        end
        OP_PUSH, OP_CALL: begin
          if (rp < RW'(RET_DEPTH)) begin
            x_rs_we = 1'b1;
            x_rp    = rp + RW'(1);
          end
          x_rs_wv = (op == OP_PUSH) ? t : cur_ip;
          if (op == OP_CALL) x_ip = t - 64'd1;
          if (d_z) x_stop = 1'b1;
          else     x_dp = dp - DW'(1);
        end
        OP_POP: begin
          if (d_room) begin
            x_w0_en = 1'b1;
            x_w0_a  = idx_push;
            x_w0_v  = r;
            x_dp    = dp + DW'(1);
          end
          if (rp != '0) x_rp = rp - RW'(1);
        end
        OP_CCALL: begin
          if (d_z) x_stop = 1'b1;
          else if (d_one) begin
            x_dp   = '0;
            x_stop = 1'b1;
          end else begin
            x_dp = dp - DW'(2);
            if (n != 64'd0) begin
              if (rp < RW'(RET_DEPTH)) begin
                x_rs_we = 1'b1;
                x_rp    = rp + RW'(1);
              end
              x_rs_wv = cur_ip;
              x_ip    = t - 64'd1;
            end
          end
        end
        OP_RET, OP_ZRET: begin
          if (op == OP_RET || t == 64'd0) begin
            if (op == OP_ZRET) begin
              if (d_z) x_stop = 1'b1;
              else     x_dp = dp - DW'(1);
            end
            x_ip = r;
            if (rp != '0) x_rp = rp - RW'(1);
          end
        end
        OP_FETCH: begin
          x_w0_en = !d_z;
          x_w0_v  = fv;
        end
        OP_STORE: begin
          if (fetch_ok) begin
            x_mem_we = 1'b1;
            if (d_z) x_stop = 1'b1;
            else if (d_one) begin
              x_dp   = '0;
              x_stop = 1'b1;
            end else x_dp = dp - DW'(2);
          end else x_stop = 1'b1;
        end
        OP_DIVM: begin
          x_w0_en = !d_z;
          x_w0_v  = divq;
          x_w1_en = d_ge2;
          x_w1_v  = divr;
        end
        OP_IOQRY: begin
          if (t == DEV_CHAR_OUT || t == DEV_CHAR_IN) begin
            // drop then push the query twice; an empty stack still halts
            x_stop  = d_z;
            x_w0_en = 1'b1;
            x_w0_a  = DAW'(base);
            x_w0_v  = t;
            if (base + DW'(1) < DW'(DATA_DEPTH)) begin
              x_w1_en = 1'b1;
              x_w1_a  = DAW'(base + DW'(1));
              x_w1_v  = t;
              x_dp    = base + DW'(2);
            end else x_dp = base + DW'(1);
          end
        end
        OP_IOACT: begin
          if (t == DEV_CHAR_OUT) begin
            if (d_z) x_stop = 1'b1;
            else if (d_one) begin
              x_dp   = '0;
              x_stop = 1'b1;
            end else begin
              x_dp   = dp - DW'(2);
              x_emit = 1'b1;
            end
          end else if (t == DEV_CHAR_IN) begin
            if (q_count == '0) x_stop = 1'b1;
            else begin
              x_pop   = 1'b1;
              x_stop  = d_z;
              x_w0_en = 1'b1;
              x_w0_a  = DAW'(base);
              x_w0_v  = {56'd0, qh_q};
              x_dp    = base + DW'(1);
            end
          end else begin
            if (d_z) x_stop = 1'b1;
            else     x_dp = dp - DW'(1);
          end
        end
        default: x_stop = 1'b1;
      endcase
    end
  end

  // port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt;
    mem_wv = 64'd0;
    if (cmd.clear_step) begin
      mem_we = 1'b1;
    end else if (cmd.do_req && r_type == REQ_LOAD && r_addr <= AW'(MEM_CELLS)) begin
      mem_we = 1'b1;
      mem_wa = r_addr;
      mem_wv = r_value;
    end else if (cmd.exec && x_mem_we) begin
      mem_we = 1'b1;
      mem_wa = t[AW-1:0];
      mem_wv = n;
    end
    mem_re = cmd.word_rd || cmd.mem_rd;
    mem_ra = cmd.word_rd ? pc : ((op == OP_LIT) ? lit_addr[AW-1:0] : t[AW-1:0]);

    ds_we = (cmd.exec && x_w0_en) || (cmd.wr2 && wr2_pend);
    ds_wa = cmd.exec ? x_w0_a : wr2_a;
    ds_wv = cmd.exec ? x_w0_v : wr2_v;

    rs_we = (cmd.do_req && r_type == REQ_START) || (cmd.exec && x_rs_we);
    rs_wa = cmd.exec ? RAW'(rp) : '0;
    rs_wv = cmd.exec ? x_rs_wv : 64'd0;

    q_we = cmd.do_req && r_type == REQ_QUEUE && q_count < QCW'(INQ_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wv;
    if (mem_re) mem_q <= mem[mem_ra];
    if (ds_we) dstk[ds_wa] <= ds_wv;
    if (rs_we) rstk[rs_wa] <= rs_wv;
    if (q_we) inq[q_tail] <= r_char;
    if (cmd.op_rd) begin
      ds_q0 <= dstk[idx_top];
      ds_q1 <= dstk[idx_sec];
      rs_q  <= rstk[RAW'(rp - RW'(1))];
      qh_q  <= inq[q_head];
    end
  end

  dsvm_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.arith_go),
    .mul  (op == OP_MUL),
    .a    ((op == OP_MUL) ? n : mb),
    .b    ((op == OP_MUL) ? t : ma),
    .busy (md_busy),
    .prod (md_prod),
    .quo  (md_quo),
    .rem  (md_rem)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_type  <= req_t'(req_type);
      r_addr  <= req_addr;
      r_value <= req_value;
      r_char  <= req_char;
    end
    if (cmd.word_lat) word <= mem_q[31:0];
    if (cmd.exec) begin
      wr2_a  <= x_w1_a;
      wr2_v  <= x_w1_v;
      emit_c <= n[7:0];
    end
    if (cmd.emit) begin
      m_tdata <= OW'(emit_c);
      m_tuser <= 1'b1;
      m_tlast <= 1'b0;
    end else if (cmd.status) begin
      m_tdata <= OW'({dp, pc, !running, 8'd0});
      m_tuser <= 1'b0;
      m_tlast <= 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      running   <= 1'b0;
      dp        <= '0;
      rp        <= '0;
      cur_ip    <= '0;
      slot      <= '0;
      q_head    <= '0;
      q_tail    <= '0;
      q_count   <= '0;
      clr_cnt   <= '0;
      stop_q    <= 1'b0;
      wr2_pend  <= 1'b0;
      emit_pend <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.clear_step && clr_cnt != AW'(MEM_CELLS)) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.do_req && r_type == REQ_START) begin
        rp      <= RW'(1);
        pc      <= r_addr;
        running <= (r_addr < AW'(MEM_CELLS));
      end
      if (q_we) begin
        q_tail  <= (q_tail == QAW'(INQ_DEPTH - 1)) ? '0 : q_tail + QAW'(1);
        q_count <= q_count + QCW'(1);
      end
      if (cmd.word_rd) begin
        cur_ip <= 64'(pc);
        slot   <= '0;
        stop_q <= 1'b0;
      end
      if (cmd.next_slot) slot <= slot + 2'd1;
      if (cmd.exec) begin
        dp        <= x_dp;
        rp        <= x_rp;
        cur_ip    <= x_ip;
        stop_q    <= x_stop;
        wr2_pend  <= x_w1_en;
        emit_pend <= x_emit;
        if (x_pop) begin
          q_head  <= (q_head == QAW'(INQ_DEPTH - 1)) ? '0 : q_head + QAW'(1);
          q_count <= q_count - QCW'(1);
        end
      end
      if (cmd.wr2) wr2_pend <= 1'b0;
      if (cmd.emit) emit_pend <= 1'b0;
      if (cmd.bundle_end) begin
        if (stop_q || rp == '0 || ip_end >= 64'(MEM_CELLS)) running <= 1'b0;
        else pc <= ip_end[AW-1:0];
      end
      if (cmd.emit || cmd.status) m_tvalid <= 1'b1;
      else if (m_tready)          m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    sts.clear_last = (clr_cnt == AW'(MEM_CELLS));
    sts.running    = running;
    sts.need_mem   = (op == OP_LIT && lit_ok) || (op == OP_FETCH && fetch_ok);
    sts.need_arith = (op == OP_MUL) || (op == OP_DIVM);
    sts.arith_busy = md_busy;
    sts.emit_pend  = emit_pend;
    sts.stop_pend  = stop_q;
    sts.last_slot  = (slot == 2'd3);
    sts.slot_free  = !m_tvalid || m_tready;
  end

endmodule

// ----- rtl/dsvm_ctrl.sv -----
// Sequencer of the word machine: walks requests, bundles and opcodes and
// drives the datapath through command and status structs. Uses dsvm_pkg.
module dsvm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic [1:0]          req_type,
  output logic                s_tready,
  output dsvm_pkg::dsvm_cmd_t cmd,
  input  dsvm_pkg::dsvm_sts_t sts
);
  import dsvm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DO, S_FETCH, S_WORD, S_OPRD, S_OPDEC, S_ARITH,
    S_EXEC, S_POST, S_EMIT, S_BEND, S_STATUS
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_op;

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = (state == S_IDLE);
    done_op    = sts.stop_pend || sts.last_slot;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (req_t'(req_type) != REQ_STEP) state_next = S_DO;
          else if (sts.running)             state_next = S_FETCH;
          else                              state_next = S_STATUS;
        end
      end
      S_DO: begin
        cmd.do_req = 1'b1;
        state_next = S_STATUS;
      end
      S_FETCH: begin
        cmd.word_rd = 1'b1;
        state_next  = S_WORD;
      end
      S_WORD: begin
        cmd.word_lat = 1'b1;
        state_next   = S_OPRD;
      end
      S_OPRD: begin
        cmd.op_rd  = 1'b1;
        state_next = S_OPDEC;
      end
      S_OPDEC: begin
        if (sts.need_arith) begin
          cmd.arith_go = 1'b1;
          state_next   = S_ARITH;
        end else begin
          cmd.mem_rd = sts.need_mem;
          state_next = S_EXEC;
        end
      end
      S_ARITH: begin
        if (!sts.arith_busy) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_POST;
      end
      S_POST: begin
        cmd.wr2 = 1'b1;
        if (sts.emit_pend) state_next = S_EMIT;
        else if (done_op)  state_next = S_BEND;
        else begin
          cmd.next_slot = 1'b1;
          state_next    = S_OPRD;
        end
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (done_op) state_next = S_BEND;
          else begin
            cmd.next_slot = 1'b1;
            state_next    = S_OPRD;
          end
        end
      end
      S_BEND: begin
        cmd.bundle_end = 1'b1;
        state_next     = S_STATUS;
      end
      S_STATUS: begin
        if (sts.slot_free) begin
          cmd.status = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  a_exec_after_arith: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !sts.arith_busy) else $error("opcode executed while arithmetic busy");
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.slot_free) else $error("character loaded over a held result");
  a_status_room: assert property (@(posedge clk) disable iff (rst)
    cmd.status |-> sts.slot_free) else $error("status loaded over a held result");
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_req, cmd.exec, cmd.emit, cmd.status, cmd.bundle_end}))
    else $error("conflicting datapath commands");

endmodule

// ----- rtl/dual_stack_vm_core.sv -----
// Top level of the dual-stack word machine core: stream ports, sequencer and datapath.
// Depends on dsvm_pkg, dsvm_ctrl, dsvm_datapath (and dsvm_muldiv below it).
//
// A 64-bit two-stack machine taking one request at a time on the slave stream.
// tuser selects the request: load a memory cell, start at an address, step one
// bundle of four opcodes, or queue an input character. Every request ends with
// one status result (tlast high); a step first gives one result per character
// written to the output device, with tuser high. After reset the block runs a
// clearing pass over all MEM_CELLS+1 cells of main memory (16385 by default)
// and holds tready low until it ends. Load, start and queue pass through a
// request state before the status result; a step while halted goes straight to
// it. A running step fetches the bundle word, then per executed opcode reads
// operands, decodes, executes, writes back and emits any character; multiply
// and divmod wait in the shared partial-product unit and bit-serial divider.
// Memory, return stack and queue reads use single registered read ports, the
// data stack two; a result waiting on the master side stalls only the next result.
module dual_stack_vm_core #(
  parameter int MEM_CELLS  = dsvm_pkg::MEM_CELLS_DEF,
  parameter int DATA_DEPTH = dsvm_pkg::DATA_DEPTH_DEF,
  parameter int RET_DEPTH  = dsvm_pkg::RET_DEPTH_DEF,
  parameter int INQ_DEPTH  = dsvm_pkg::INQ_DEPTH_DEF,
  localparam int AW = $clog2(MEM_CELLS + 1),
  localparam int DW = $clog2(DATA_DEPTH + 1),
  localparam int IW = ((AW + 64 + 8 + 7) / 8) * 8,
  localparam int OW = ((8 + 1 + AW + DW + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst,
  // request stream
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [IW-1:0] s_tdata,   // cell_addr, cell_value, char_in (low bit up)
  input  logic [1:0]    s_tuser,   // req_type
  // result stream
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [OW-1:0] m_tdata,   // char_out, halted, instr_pointer, data_level
  output logic          m_tuser,   // char_valid
  output logic          m_tlast    // last
);
  import dsvm_pkg::*;

  dsvm_cmd_t cmd;
  dsvm_sts_t sts;

  // sequencer: request, bundle and opcode stepping
  dsvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .req_type (s_tuser),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: memories, stacks, queue, execution, result register
  dsvm_datapath #(
    .MEM_CELLS  (MEM_CELLS),
    .DATA_DEPTH (DATA_DEPTH),
    .RET_DEPTH  (RET_DEPTH),
    .INQ_DEPTH  (INQ_DEPTH),
    .AW         (AW),
    .DW         (DW),
    .OW         (OW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_type  (s_tuser),
    .req_addr  (s_tdata[AW-1:0]),
    .req_value (s_tdata[AW+63:AW]),
    .req_char  (s_tdata[AW+71:AW+64]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
